/* hw/rtl/bcu_pkg.sv */
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the binomial coefficient unit: widths,
// microcode word layout, datapath operations and jump conditions.
// ----------------------------------------------------------------------------
package bcu_pkg;

   localparam int IDX_W  = 6;   // row and column index width
   localparam int COEF_W = 60;  // coefficient width
   localparam int MUL_W  = 6;   // multiplier operand (n-k+j), at most 63
   localparam int PROD_W = COEF_W + MUL_W;  // full product, never wraps
   localparam int CNT_W  = 7;   // divide step counter, holds PROD_W-1
   localparam int PC_W   = 3;   // microcode address width

   // Microcode addresses
   localparam logic [PC_W-1:0] UA_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] UA_CHECK = 3'd1;
   localparam logic [PC_W-1:0] UA_TEST  = 3'd2;
   localparam logic [PC_W-1:0] UA_MUL   = 3'd3;
   localparam logic [PC_W-1:0] UA_DIV   = 3'd4;
   localparam logic [PC_W-1:0] UA_STORE = 3'd5;
   localparam logic [PC_W-1:0] UA_DONE  = 3'd6;
   localparam logic [PC_W-1:0] UA_BAD   = 3'd7;

   typedef enum logic [2:0] {
      OP_LOAD,    // capture request fields
      OP_INIT,    // acc = 1, j = 0
      OP_NOP,
      OP_MUL,     // j = j+1, prod = acc * (n-k+j)
      OP_DIV,     // one restoring divide step by j
      OP_STORE,   // acc = quotient
      OP_DONE,    // post coefficient
      OP_BAD      // post zero with error flag
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_START,
      COND_BAD,
      COND_J_EQ_K,
      COND_CNT_NZ
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic bad;
      logic j_eq_k;
      logic cnt_nz;
   } flags_type;

endpackage

/* hw/rtl/binomial_coefficient_unit_core.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient_unit_core
// Computes C(n,k) by the recurrence C(n-k+j,j) = (n-k+j) * C(n-k+j-1,j-1) / j
// for j = 1..k under microcode control, with a full-width product and an exact
// serial divide.
//   channel   ports                                      handshake
//   request   req_row_index, req_col_index               start & !busy
//   response  rsp_coefficient, rsp_bad_index             rsp_valid, 1 cycle
//
// A valid request runs k recurrence steps after acceptance before the response
// strobe; an invalid request goes straight from the check to the response.
// Each recurrence step is one multiply, 66 one-bit divide steps and a store.
// busy drops in the cycle the response strobes; a new request may start then.
// Synchronous reset returns the sequencer to idle and clears the strobe.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit_core #(
   parameter int MAX_ROWS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [bcu_pkg::IDX_W-1:0]   req_row_index,
   input  logic [bcu_pkg::IDX_W-1:0]   req_col_index,
   output logic                        rsp_valid,
   output logic [bcu_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic                        rsp_bad_index
);

   logic [bcu_pkg::PC_W-1:0] upc;
   bcu_pkg::uword_type       uword;
   bcu_pkg::flags_type       flags;

   bcu_ucode_rom u_rom (
      .upc   (upc),
      .uword (uword)
   );

   bcu_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .uword (uword),
      .flags (flags),
      .upc   (upc),
      .busy  (busy)
   );

   bcu_datapath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (uword.op),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_coefficient (rsp_coefficient),
      .rsp_bad_index   (rsp_bad_index)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response strobe outside end of transaction");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_index) |-> (rsp_coefficient == '0))
      else $error("bad index response with nonzero coefficient");

   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_index) |-> (rsp_coefficient != '0))
      else $error("valid response with zero coefficient");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");
`endif

endmodule

/* hw/rtl/bcu_ucode_rom.sv */
// ----------------------------------------------------------------------------
// bcu_ucode_rom
// Read-only control store of the binomial coefficient sequencer.
// ----------------------------------------------------------------------------
module bcu_ucode_rom (
   input  logic [bcu_pkg::PC_W-1:0] upc,
   output bcu_pkg::uword_type       uword
);

   always_comb begin
      unique case (upc)
         bcu_pkg::UA_IDLE:  uword = '{bcu_pkg::OP_LOAD,  bcu_pkg::COND_NO_START,
                                     bcu_pkg::UA_IDLE};
         bcu_pkg::UA_CHECK: uword = '{bcu_pkg::OP_INIT,  bcu_pkg::COND_BAD,
                                     bcu_pkg::UA_BAD};
         bcu_pkg::UA_TEST:  uword = '{bcu_pkg::OP_NOP,   bcu_pkg::COND_J_EQ_K,
                                     bcu_pkg::UA_DONE};
         bcu_pkg::UA_MUL:   uword = '{bcu_pkg::OP_MUL,   bcu_pkg::COND_ALWAYS,
                                     bcu_pkg::UA_DIV};
         bcu_pkg::UA_DIV:   uword = '{bcu_pkg::OP_DIV,   bcu_pkg::COND_CNT_NZ,
                                     bcu_pkg::UA_DIV};
         bcu_pkg::UA_STORE: uword = '{bcu_pkg::OP_STORE, bcu_pkg::COND_ALWAYS,
                                     bcu_pkg::UA_TEST};
         bcu_pkg::UA_DONE:  uword = '{bcu_pkg::OP_DONE,  bcu_pkg::COND_ALWAYS,
                                     bcu_pkg::UA_IDLE};
         bcu_pkg::UA_BAD:   uword = '{bcu_pkg::OP_BAD,   bcu_pkg::COND_ALWAYS,
                                     bcu_pkg::UA_IDLE};
         default:           uword = '{bcu_pkg::OP_NOP,   bcu_pkg::COND_ALWAYS,
                                     bcu_pkg::UA_IDLE};
      endcase
   end

endmodule

/* hw/rtl/bcu_sequencer.sv */
// ----------------------------------------------------------------------------
// bcu_sequencer
// Microcode step counter with conditional jumps.
// ----------------------------------------------------------------------------
module bcu_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bcu_pkg::uword_type       uword,
   input  bcu_pkg::flags_type       flags,
   output logic [bcu_pkg::PC_W-1:0] upc,
   output logic                     busy
);

   logic [bcu_pkg::PC_W-1:0] upc_ff;
   logic [bcu_pkg::PC_W-1:0] upc_in;
   logic                     take;

   always_comb begin
      unique case (uword.cond)
         bcu_pkg::COND_ALWAYS:   take = 1'b1;
         bcu_pkg::COND_NO_START: take = !start;
         bcu_pkg::COND_BAD:      take = flags.bad;
         bcu_pkg::COND_J_EQ_K:   take = flags.j_eq_k;
         bcu_pkg::COND_CNT_NZ:   take = flags.cnt_nz;
         default:                take = 1'b1;
      endcase
   end

   always_comb begin
      upc_in = take ? uword.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= bcu_pkg::UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign upc  = upc_ff;
   assign busy = (upc_ff != bcu_pkg::UA_IDLE);

endmodule

/* hw/rtl/bcu_datapath.sv */
// ----------------------------------------------------------------------------
// bcu_datapath
// Accumulator, multiplier and bit-serial exact divider driven by microcode.
// ----------------------------------------------------------------------------
module bcu_datapath #(
   parameter int MAX_ROWS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bcu_pkg::op_type             op,
   input  logic [bcu_pkg::IDX_W-1:0]   req_row_index,
   input  logic [bcu_pkg::IDX_W-1:0]   req_col_index,
   output bcu_pkg::flags_type          flags,
   output logic                        rsp_valid,
   output logic [bcu_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic                        rsp_bad_index
);

   localparam int IW = bcu_pkg::IDX_W;
   localparam int CW = bcu_pkg::COEF_W;
   localparam int PW = bcu_pkg::PROD_W;
   localparam int NW = bcu_pkg::CNT_W;

   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] j_ff, j_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic [PW-1:0] div_ff, div_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;
   logic [CW-1:0] coef_ff, coef_in;
   logic          bad_ff, bad_in;

   logic [IW-1:0]            j_next;
   logic [bcu_pkg::MUL_W-1:0] mult;
   logic [PW-1:0]            prod;
   logic [IW:0]              trial;
   logic                     ge;

   assign j_next = j_ff + 1'b1;
   assign mult   = n_ff - k_ff + j_next;
   assign prod   = PW'(acc_ff) * PW'(mult);
   assign trial  = {rem_ff, div_ff[PW-1]};
   assign ge     = (trial >= {1'b0, j_ff});

   assign flags.bad    = (k_ff > n_ff) || ({1'b0, n_ff} >= (IW+1)'(MAX_ROWS));
   assign flags.j_eq_k = (j_ff == k_ff);
   assign flags.cnt_nz = (cnt_ff != '0);

   always_comb begin
      n_in     = n_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      acc_in   = acc_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      coef_in  = coef_ff;
      bad_in   = bad_ff;
      unique case (op)
         bcu_pkg::OP_LOAD: begin
            n_in = req_row_index;
            k_in = req_col_index;
         end
         bcu_pkg::OP_INIT: begin
            acc_in = CW'(1);
            j_in   = '0;
         end
         bcu_pkg::OP_NOP: begin
         end
         bcu_pkg::OP_MUL: begin
            j_in   = j_next;
            div_in = prod;
            rem_in = '0;
            cnt_in = NW'(PW - 1);
         end
         bcu_pkg::OP_DIV: begin
            // shift in one dividend bit, subtract when the divisor fits
            div_in = {div_ff[PW-2:0], ge};
            rem_in = ge ? IW'(trial - {1'b0, j_ff}) : IW'(trial);
            cnt_in = cnt_ff - 1'b1;
         end
         bcu_pkg::OP_STORE: begin
            acc_in = div_ff[CW-1:0];
         end
         bcu_pkg::OP_DONE: begin
            valid_in = 1'b1;
            coef_in  = acc_ff;
            bad_in   = 1'b0;
         end
         bcu_pkg::OP_BAD: begin
            valid_in = 1'b1;
            coef_in  = '0;
            bad_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      j_ff    <= j_in;
      acc_ff  <= acc_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      coef_ff <= coef_in;
      bad_ff  <= bad_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_bad_index   = bad_ff;

endmodule
